### hw/rtl/kbfi_pkg.sv
// Shared types, constants and the king view setup for the king bucket feature indexer.
package kbfi_pkg;

    localparam int unsigned SQ_W      = 6;
    localparam int unsigned BUCKET_W  = 3;
    localparam int unsigned FEATURE_W = 13;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned SQUARES   = 64;

    localparam logic [SQ_W-1:0]      FLIP_V        = 6'd56;
    localparam logic [SQ_W-1:0]      FLIP_H        = 6'd7;
    localparam logic [FEATURE_W-1:0] BUCKET_STRIDE = 13'd768;
    localparam logic [FEATURE_W-1:0] COLOUR_STRIDE = 13'd384;
    localparam logic [FEATURE_W-1:0] TYPE_STRIDE   = 13'd64;

    // one perspective: its colour, king bucket and horizontal mirror
    typedef struct packed {
        logic                black;
        logic [BUCKET_W-1:0] bucket;
        logic                mirror;
    } view_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    function automatic view_t view_setup(input logic [SQ_W-1:0] ksq, input logic black);
        logic [SQ_W-1:0] k;
        view_t           v;
        k        = black ? (ksq ^ FLIP_V) : ksq;
        v.black  = black;
        v.mirror = k[2];
        // the file mirror leaves the rank alone
        v.bucket = k[5:3];
        return v;
    endfunction

endpackage

### hw/rtl/kbfi_feature_unit.sv
// Feature index of one occupied square from one perspective.
module kbfi_feature_unit
(
    input  kbfi_pkg::view_t                   view,
    input  logic [kbfi_pkg::SQ_W-1:0]         square,
    input  logic [kbfi_pkg::NIBBLE_W-1:0]     piece,
    output logic [kbfi_pkg::FEATURE_W-1:0]    feature
);

    logic                          rel;
    logic [kbfi_pkg::SQ_W-1:0]     psq;
    logic [kbfi_pkg::SQ_W-1:0]     msq;
    logic [kbfi_pkg::FEATURE_W-1:0] bucket_off;
    logic [kbfi_pkg::FEATURE_W-1:0] colour_off;
    logic [kbfi_pkg::FEATURE_W-1:0] type_off;

    always_comb
    begin
        rel        = piece[3] != view.black;
        psq        = view.black ? (square ^ kbfi_pkg::FLIP_V) : square;
        msq        = view.mirror ? (psq ^ kbfi_pkg::FLIP_H) : psq;
        bucket_off = kbfi_pkg::FEATURE_W'(view.bucket) * kbfi_pkg::BUCKET_STRIDE;
        colour_off = rel ? kbfi_pkg::COLOUR_STRIDE : '0;
        type_off   = kbfi_pkg::FEATURE_W'(piece[2:0]) * kbfi_pkg::TYPE_STRIDE;
        feature    = bucket_off + colour_off + type_off + kbfi_pkg::FEATURE_W'(msq);
    end

endmodule

### hw/rtl/king_bucket_feature_indexer.sv
// Top level: takes a position and streams one feature pair per occupied square.
//
// Input channel (in_valid / in_stall): one word is a whole position, the side
// to move, both king squares, the occupancy bitboard and four words of piece
// nibbles. in_stall is high while a position is being scanned.
// Output channel (out_valid / out_stall): one word per occupied square in
// ascending square order, carrying both feature indices; last_piece marks
// the highest occupied square. An empty board gives no words.
// Timing: the position is first loaded into the scan registers, and each word
// is then registered into the output register. The scan unit finds the lowest
// remaining occupied square with a single isolate-and-clear step each cycle
// while the output register is free; in_stall stays high until the last
// occupied square has been loaded into the output register.
// The next position is taken while the final word may still sit unread.
// When the receiver stalls the output register holds and the scan waits.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties
// the output register; no word in flight survives it.
module king_bucket_feature_indexer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        black_to_move,
    input  logic [5:0]  mover_king_square,
    input  logic [5:0]  other_king_square,
    input  logic [63:0] occupied_squares,
    input  logic [63:0] piece_codes_0_15,
    input  logic [63:0] piece_codes_16_31,
    input  logic [63:0] piece_codes_32_47,
    input  logic [63:0] piece_codes_48_63,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] mover_feature,
    output logic [12:0] other_feature,
    output logic        last_piece
);

    localparam int unsigned PIECE_BITS = kbfi_pkg::SQUARES * kbfi_pkg::NIBBLE_W;

    kbfi_pkg::state_t state_reg, state_next;
    logic [kbfi_pkg::SQUARES-1:0] rem_reg, rem_next;
    logic [PIECE_BITS-1:0]        pieces_reg;
    kbfi_pkg::view_t              mover_view_reg;
    kbfi_pkg::view_t              other_view_reg;

    logic                         out_valid_reg;
    logic [kbfi_pkg::FEATURE_W-1:0] mover_feature_reg;
    logic [kbfi_pkg::FEATURE_W-1:0] other_feature_reg;
    logic                         last_piece_reg;

    logic                         in_accept;
    logic                         out_free;
    logic                         load;
    logic [kbfi_pkg::SQUARES-1:0] low_oh;
    logic [kbfi_pkg::SQUARES-1:0] rem_cleared;
    logic [kbfi_pkg::SQ_W-1:0]    cur_sq;
    logic [kbfi_pkg::NIBBLE_W-1:0] cur_piece;
    logic [kbfi_pkg::FEATURE_W-1:0] mover_feature_calc;
    logic [kbfi_pkg::FEATURE_W-1:0] other_feature_calc;

    assign in_stall  = state_reg != kbfi_pkg::ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // isolate the lowest remaining occupied square
    assign low_oh      = rem_reg & (~rem_reg + 64'd1);
    assign rem_cleared = rem_reg & ~low_oh;

    always_comb
    begin
        cur_sq = '0;
        for (int i = 0; i < kbfi_pkg::SQUARES; i++)
        begin
            if (low_oh[i])
            begin
                cur_sq = cur_sq | kbfi_pkg::SQ_W'(i);
            end
        end
    end

    assign cur_piece = pieces_reg[{cur_sq, 2'b00} +: kbfi_pkg::NIBBLE_W];

    kbfi_feature_unit u_mover_feature
    (
        .view    (mover_view_reg),
        .square  (cur_sq),
        .piece   (cur_piece),
        .feature (mover_feature_calc)
    );

    kbfi_feature_unit u_other_feature
    (
        .view    (other_view_reg),
        .square  (cur_sq),
        .piece   (cur_piece),
        .feature (other_feature_calc)
    );

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        load       = 1'b0;
        case (state_reg)
            kbfi_pkg::ST_IDLE:
            begin
                if (in_valid && occupied_squares != '0)
                begin
                    state_next = kbfi_pkg::ST_SCAN;
                    rem_next   = occupied_squares;
                end
            end
            kbfi_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    rem_next = rem_cleared;
                    if (rem_cleared == '0)
                    begin
                        state_next = kbfi_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = kbfi_pkg::ST_IDLE;
                rem_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kbfi_pkg::ST_IDLE;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pieces_reg     <= {piece_codes_48_63, piece_codes_32_47,
                               piece_codes_16_31, piece_codes_0_15};
            mover_view_reg <= kbfi_pkg::view_setup(mover_king_square, black_to_move);
            other_view_reg <= kbfi_pkg::view_setup(other_king_square, !black_to_move);
        end
        if (load)
        begin
            mover_feature_reg <= mover_feature_calc;
            other_feature_reg <= other_feature_calc;
            last_piece_reg    <= rem_cleared == '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mover_feature = mover_feature_reg;
    assign other_feature = other_feature_reg;
    assign last_piece    = last_piece_reg;

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kbfi_pkg::ST_SCAN |-> rem_reg != '0)
        else $error("scanning with no occupied squares left");

    a_accept_loads_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && occupied_squares != '0
        |=> state_reg == kbfi_pkg::ST_SCAN && rem_reg == $past(occupied_squares))
        else $error("position not loaded into the scan");

    a_empty_board_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && occupied_squares == '0 |=> state_reg == kbfi_pkg::ST_IDLE)
        else $error("empty board left the sequencer busy");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        load && rem_cleared == '0
        |=> state_reg == kbfi_pkg::ST_IDLE && out_valid_reg && last_piece_reg)
        else $error("final word did not end the scan");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> state_reg == kbfi_pkg::ST_SCAN && out_free)
        else $error("output register overwritten while stalled");

endmodule
